[rtl/amx_pkg.sv]
package amx_pkg;

    localparam int ENTRY_WIDTH = 32;
    localparam int FRAC_BITS = 16;

    localparam int EW = ENTRY_WIDTH;
    localparam int PW = 2 * EW;
    localparam int AW = 2 * EW + 1;
    localparam int LOW = EW + 1;
    localparam int HIW = AW - LOW;
    localparam int DW = 3 * EW + 3;
    localparam int NLW = AW + 2 * FRAC_BITS;
    localparam int NTW = DW + FRAC_BITS;
    localparam int NW = (NLW > NTW) ? NLW : NTW;
    localparam int RW = (NW > DW + EW + 1) ? NW : DW + EW + 1;
    localparam int LANES = 4;

    typedef logic signed [EW-1:0] entry_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [AW-1:0] adj_t;
    typedef logic signed [EW+LOW:0] lo_t;
    typedef logic signed [EW+HIW-1:0] hi_t;
    typedef logic signed [DW-1:0] wide_t;
    typedef logic [RW-1:0] rem_t;
    typedef logic [1:0] row_t;

    localparam row_t FIRST_ROW = 2'd0;
    localparam row_t LAST_ROW = 2'd2;

    typedef struct packed {
        entry_t [2:0][2:0] m;
        entry_t [2:0] t;
    } item_t;

    typedef struct packed {
        adj_t [2:0] adj;
        adj_t [2:0] adjc;
        entry_t [2:0] t;
        entry_t [2:0] m0;
        row_t row;
    } cof_t;

    typedef struct packed {
        rem_t [LANES-1:0] num;
        logic [LANES-1:0] neg;
        rem_t den;
        logic sing;
        row_t row;
    } quo_in_t;

    function automatic row_t next3(input row_t v);
        next3 = (v == LAST_ROW) ? FIRST_ROW : v + 2'd1;
    endfunction

endpackage

[rtl/amx_cofactor.sv]
module amx_cofactor (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  amx_pkg::item_t item,
    input  amx_pkg::row_t  row,
    output logic           out_valid,
    output amx_pkg::cof_t  out
);
    import amx_pkg::*;

    prod_t [2:0] pa_next, pb_next, ca_next, cb_next;
    prod_t [2:0] pa_reg, pb_reg, ca_reg, cb_reg;
    entry_t [2:0] t1_reg, m01_reg;
    row_t row1_reg;
    logic v1_reg, v2_reg;
    cof_t cof_next, cof_reg;
    row_t c0, c1;

    always_comb
    begin
        c0 = next3(row);
        c1 = next3(c0);
        for (int j = 0; j < 3; j++)
        begin
            pa_next[j] = item.m[next3(row_t'(j))][c0] * item.m[next3(next3(row_t'(j)))][c1];
            pb_next[j] = item.m[next3(row_t'(j))][c1] * item.m[next3(next3(row_t'(j)))][c0];
            ca_next[j] = item.m[1][next3(row_t'(j))] * item.m[2][next3(next3(row_t'(j)))];
            cb_next[j] = item.m[1][next3(next3(row_t'(j)))] * item.m[2][next3(row_t'(j))];
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            cof_next.adj[j] = adj_t'(pa_reg[j]) - adj_t'(pb_reg[j]);
            cof_next.adjc[j] = adj_t'(ca_reg[j]) - adj_t'(cb_reg[j]);
        end
        cof_next.t = t1_reg;
        cof_next.m0 = m01_reg;
        cof_next.row = row1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            ca_reg <= ca_next;
            cb_reg <= cb_next;
            t1_reg <= item.t;
            m01_reg <= item.m[0];
            row1_reg <= row;
            cof_reg <= cof_next;
        end
    end

    assign out_valid = v2_reg;
    assign out = cof_reg;

endmodule

[rtl/amx_det.sv]
module amx_det (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  amx_pkg::cof_t    cof,
    output logic             out_valid,
    output amx_pkg::quo_in_t out
);
    import amx_pkg::*;

    lo_t [2:0] dlo_reg, alo_reg;
    hi_t [2:0] dhi_reg, ahi_reg;
    adj_t [2:0] adj3_reg, adj4_reg, adj5_reg;
    row_t row3_reg, row4_reg, row5_reg;
    wide_t [2:0] pd_next, pt_next, pd_reg, pt_reg;
    wide_t det_reg, acc_reg;
    logic [3:0] v_reg;
    quo_in_t q_next, q_reg;
    logic [DW-1:0] dmag, tmag;
    logic [AW-1:0] amag;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pd_next[k] = (wide_t'(dhi_reg[k]) <<< LOW) + wide_t'(dlo_reg[k]);
            pt_next[k] = (wide_t'(ahi_reg[k]) <<< LOW) + wide_t'(alo_reg[k]);
        end
    end

    always_comb
    begin
        dmag = det_reg[DW-1] ? -det_reg : det_reg;
        tmag = acc_reg[DW-1] ? -acc_reg : acc_reg;
        amag = '0;
        for (int j = 0; j < 3; j++)
        begin
            amag = adj5_reg[j][AW-1] ? -adj5_reg[j] : adj5_reg[j];
            q_next.num[j] = rem_t'(amag) << (2 * FRAC_BITS);
            q_next.neg[j] = adj5_reg[j][AW-1] ^ det_reg[DW-1];
        end
        q_next.num[3] = rem_t'(tmag) << FRAC_BITS;
        q_next.neg[3] = (!acc_reg[DW-1] && (acc_reg != '0)) ^ det_reg[DW-1];
        q_next.den = rem_t'(dmag);
        q_next.sing = (det_reg == '0);
        q_next.row = row5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dlo_reg[k] <= cof.m0[k] * $signed({1'b0, cof.adjc[k][LOW-1:0]});
                dhi_reg[k] <= cof.m0[k] * $signed(cof.adjc[k][AW-1:LOW]);
                alo_reg[k] <= cof.t[k] * $signed({1'b0, cof.adj[k][LOW-1:0]});
                ahi_reg[k] <= cof.t[k] * $signed(cof.adj[k][AW-1:LOW]);
            end
            adj3_reg <= cof.adj;
            row3_reg <= cof.row;
            pd_reg <= pd_next;
            pt_reg <= pt_next;
            adj4_reg <= adj3_reg;
            row4_reg <= row3_reg;
            det_reg <= pd_reg[0] + pd_reg[1] + pd_reg[2];
            acc_reg <= pt_reg[0] + pt_reg[1] + pt_reg[2];
            adj5_reg <= adj4_reg;
            row5_reg <= row4_reg;
            q_reg <= q_next;
        end
    end

    assign out_valid = v_reg[3];
    assign out = q_reg;

endmodule

[rtl/amx_divider.sv]
module amx_divider (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  amx_pkg::quo_in_t                       quo,
    output logic                                   out_valid,
    output amx_pkg::row_t                          row_index,
    output amx_pkg::entry_t [amx_pkg::LANES-1:0]   col,
    output logic                                   singular,
    output logic                                   last_row
);
    import amx_pkg::*;

    typedef struct packed {
        rem_t [LANES-1:0] r;
        logic [LANES-1:0][EW-1:0] q;
        logic [LANES-1:0] over;
        logic [LANES-1:0] neg;
        rem_t den;
        logic sing;
        row_t row;
    } dv_t;

    dv_t st_next [EW+1];
    dv_t st_reg [EW+1];
    logic [EW:0] sv_reg;
    entry_t [LANES-1:0] col_next, col_reg;
    logic out_valid_reg, sing_reg, last_reg;
    row_t row_reg;
    logic [EW:0] qr, lim, mag;

    always_comb
    begin
        st_next[0].r = quo.num;
        st_next[0].q = '0;
        st_next[0].neg = quo.neg;
        st_next[0].den = quo.den;
        st_next[0].sing = quo.sing;
        st_next[0].row = quo.row;
        for (int l = 0; l < LANES; l++)
        begin
            st_next[0].over[l] = (quo.num[l] >= (quo.den << EW));
        end
        for (int s = 1; s <= EW; s++)
        begin
            st_next[s] = st_reg[s-1];
            for (int l = 0; l < LANES; l++)
            begin
                if (st_reg[s-1].r[l] >= (st_reg[s-1].den << (EW - s)))
                begin
                    st_next[s].r[l] = st_reg[s-1].r[l] - (st_reg[s-1].den << (EW - s));
                    st_next[s].q[l][EW-s] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        qr = '0;
        lim = '0;
        mag = '0;
        for (int l = 0; l < LANES; l++)
        begin
            qr = {1'b0, st_reg[EW].q[l]}
                + (EW+1)'((st_reg[EW].r[l] << 1) >= st_reg[EW].den);
            lim = (EW+1)'(1) << (EW - 1);
            if (!st_reg[EW].neg[l])
            begin
                lim = lim - (EW+1)'(1);
            end
            mag = (st_reg[EW].over[l] || (qr > lim)) ? lim : qr;
            if (st_reg[EW].sing)
            begin
                col_next[l] = '0;
            end
            else if (st_reg[EW].neg[l])
            begin
                col_next[l] = -mag[EW-1:0];
            end
            else
            begin
                col_next[l] = mag[EW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg <= {sv_reg[EW-1:0], in_valid};
            out_valid_reg <= sv_reg[EW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s <= EW; s++)
            begin
                st_reg[s] <= st_next[s];
            end
            col_reg <= col_next;
            row_reg <= st_reg[EW].row;
            sing_reg <= st_reg[EW].sing;
            last_reg <= (st_reg[EW].row == LAST_ROW);
        end
    end

    assign out_valid = out_valid_reg;
    assign row_index = row_reg;
    assign col = col_reg;
    assign singular = sing_reg;
    assign last_row = last_reg;

endmodule

[rtl/affine_matrix_inverse.sv]
// Channel | Signals                                   | Beat
// input   | in_valid, in_ready, m00..m22, t0..t2      | one affine transform
// output  | out_valid, out_ready, row_index, col0..3, | one row of the inverse
//         | singular, last_row                        |
//
// Each transform is held in an input register and issued as three row beats,
// one per cycle unless the output stalls; a new transform can be taken as the
// last row beat of the previous one issues. That rate is set by the single row
// pipeline feeding the output channel. The first row passes through 2 adjugate
// stages, 4 determinant stages, an overflow check, 32 quotient stages and the output.
// Reset clears the valid bits and the row counter. A stall on the output
// freezes every stage.
module affine_matrix_inverse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  amx_pkg::entry_t  m00,
    input  amx_pkg::entry_t  m01,
    input  amx_pkg::entry_t  m02,
    input  amx_pkg::entry_t  t0,
    input  amx_pkg::entry_t  m10,
    input  amx_pkg::entry_t  m11,
    input  amx_pkg::entry_t  m12,
    input  amx_pkg::entry_t  t1,
    input  amx_pkg::entry_t  m20,
    input  amx_pkg::entry_t  m21,
    input  amx_pkg::entry_t  m22,
    input  amx_pkg::entry_t  t2,
    output logic             out_valid,
    input  logic             out_ready,
    output amx_pkg::row_t    row_index,
    output amx_pkg::entry_t  col0,
    output amx_pkg::entry_t  col1,
    output amx_pkg::entry_t  col2,
    output amx_pkg::entry_t  col3,
    output logic             singular,
    output logic             last_row
);
    import amx_pkg::*;

    item_t item_reg, item_next;
    logic item_valid_reg;
    row_t row_reg;
    logic en, feed, accept;
    logic cof_valid, det_valid;
    cof_t cof;
    quo_in_t quo;
    entry_t [LANES-1:0] col;

    assign en = !out_valid || out_ready;
    assign feed = item_valid_reg && en;
    assign in_ready = !item_valid_reg || (feed && (row_reg == LAST_ROW));
    assign accept = in_valid && in_ready;

    always_comb
    begin
        item_next.m[0][0] = m00;
        item_next.m[0][1] = m01;
        item_next.m[0][2] = m02;
        item_next.m[1][0] = m10;
        item_next.m[1][1] = m11;
        item_next.m[1][2] = m12;
        item_next.m[2][0] = m20;
        item_next.m[2][1] = m21;
        item_next.m[2][2] = m22;
        item_next.t[0] = t0;
        item_next.t[1] = t1;
        item_next.t[2] = t2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            row_reg <= FIRST_ROW;
        end
        else
        begin
            if (feed)
            begin
                row_reg <= next3(row_reg);
            end
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (feed && (row_reg == LAST_ROW))
            begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    amx_cofactor u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (item_valid_reg),
        .item      (item_reg),
        .row       (row_reg),
        .out_valid (cof_valid),
        .out       (cof)
    );

    amx_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cof_valid),
        .cof       (cof),
        .out_valid (det_valid),
        .out       (quo)
    );

    amx_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (det_valid),
        .quo       (quo),
        .out_valid (out_valid),
        .row_index (row_index),
        .col       (col),
        .singular  (singular),
        .last_row  (last_row)
    );

    assign col0 = col[0];
    assign col1 = col[1];
    assign col2 = col[2];
    assign col3 = col[3];

endmodule
